// File: hw/rtl/lpv_pkg.sv
// Shared types, codes and constants of the LED package validator.
package lpv_pkg;

	localparam int HEADER_BYTES = 32;
	localparam int PALETTE_MAX  = 16;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;
	localparam logic [7:0]  ROLE_NONE = 8'd255;

	localparam logic [31:0] MAGIC_WORD  = 32'h3146454C;
	localparam logic [7:0]  VERSION_ONE = 8'd1;

	// Result status codes.
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_TRUNC = 3'd1;
	localparam logic [2:0] ST_MAGIC = 3'd2;
	localparam logic [2:0] ST_TOPO  = 3'd3;
	localparam logic [2:0] ST_HDR   = 3'd4;
	localparam logic [2:0] ST_SIZE  = 3'd5;
	localparam logic [2:0] ST_CRC   = 3'd6;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_WIDTH      = 3'd0;
	localparam logic [2:0] REG_HEIGHT     = 3'd1;
	localparam logic [2:0] REG_RATE       = 3'd2;
	localparam logic [2:0] REG_TICKS      = 3'd3;
	localparam logic [2:0] REG_FRAME_SIZE = 3'd4;

	typedef struct packed {
		logic [7:0]  width;
		logic [7:0]  height;
		logic [7:0]  rate;
		logic [7:0]  ticks;
		logic [15:0] frame_size;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  fault;    // ST_OK, ST_MAGIC, ST_TOPO or ST_HDR
		logic        size_ok;  // declared payload matches the layout
		logic [32:0] total;    // expected file length
	} verdict_t;

endpackage

// File: hw/rtl/lpv_header_check.sv
// Combinational verdict on a complete 32-byte package header.
module lpv_header_check (
	input  logic [8*lpv_pkg::HEADER_BYTES-1:0] hdr,
	input  lpv_pkg::cfg_t                      cfg,
	output lpv_pkg::verdict_t                  verdict
);

	logic [7:0]  version, width, height, rate, ticks, frames, pal, flags;
	logic [7:0]  role_p, role_s, role_a;
	logic [15:0] frame_bytes, header_bytes;
	logic [31:0] magic, payload;
	logic [23:0] frame_total;
	logic [31:0] expected;
	logic        magic_bad, topo_bad, hdr_bad;

	function automatic logic role_ok(input logic [7:0] idx, input logic [7:0] p);
		return (idx == lpv_pkg::ROLE_NONE) || (idx < p);
	endfunction

	assign magic        = hdr[31:0];
	assign version      = hdr[39:32];
	assign width        = hdr[47:40];
	assign height       = hdr[55:48];
	assign rate         = hdr[63:56];
	assign ticks        = hdr[71:64];
	assign frames       = hdr[79:72];
	assign pal          = hdr[87:80];
	assign flags        = hdr[95:88];
	assign frame_bytes  = hdr[111:96];
	assign header_bytes = hdr[127:112];
	assign payload      = hdr[159:128];
	assign role_p       = hdr[199:192];
	assign role_s       = hdr[207:200];
	assign role_a       = hdr[215:208];

	assign magic_bad = (magic != lpv_pkg::MAGIC_WORD) || (version != lpv_pkg::VERSION_ONE);

	assign topo_bad = (width != cfg.width) || (height != cfg.height) ||
		(rate != cfg.rate) || (ticks != cfg.ticks) ||
		(frame_bytes != cfg.frame_size) ||
		(header_bytes != 16'(lpv_pkg::HEADER_BYTES)) || (flags != 8'd0);

	assign hdr_bad = (frames == 8'd0) || (frames > cfg.ticks) ||
		(pal == 8'd0) || (pal > 8'(lpv_pkg::PALETTE_MAX)) ||
		!role_ok(role_p, pal) || !role_ok(role_s, pal) || !role_ok(role_a, pal);

	assign frame_total = 24'(frames) * 24'(frame_bytes);
	assign expected    = 32'(pal) * 32'd3 + 32'(ticks) + 32'(frame_total);

	always_comb begin
		priority if (magic_bad) begin
			verdict.fault = lpv_pkg::ST_MAGIC;
		end else if (topo_bad) begin
			verdict.fault = lpv_pkg::ST_TOPO;
		end else if (hdr_bad) begin
			verdict.fault = lpv_pkg::ST_HDR;
		end else begin
			verdict.fault = lpv_pkg::ST_OK;
		end
		verdict.size_ok = (payload == expected);
		verdict.total   = {1'b0, payload} + 33'(lpv_pkg::HEADER_BYTES);
	end

endmodule

// File: hw/rtl/lpv_crc8.sv
// Reflected CRC-32 update over one byte.
module lpv_crc8 (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	output logic [31:0] crc_out
);

	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? lpv_pkg::CRC_POLY : 32'd0);
		end
		crc_out = c;
	end

endmodule

// File: hw/rtl/led_package_validator_top.sv
// Top level of the LED package validator: input stage, stream state and result register.
// A byte is registered in the input stage; once the final byte advances, its result is
// loaded into the output register. Throughput: one byte per cycle, set by the byte-wide
// CRC step and counter update, except that a final byte waits while a result is unread.
// Reset clears the stream counter, CRC, header verdict, valid flags and registers to defaults;
// the header store is not cleared and is fully rewritten by each file before it is read.
module led_package_validator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] payload_crc,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lpv_pkg::cfg_t cfg_q;

	logic        valid_s1, fin_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	logic [31:0] cnt_q, cnt_next;
	logic [31:0] crc_q, crc_upd, crc_next;
	logic [8*lpv_pkg::HEADER_BYTES-1:0] hdr_q;
	logic [2:0]  fault_q;
	logic        size_ok_q;
	logic [32:0] total_q;

	lpv_pkg::verdict_t verdict, verdict_use;
	logic        in_header, header_last;
	logic [2:0]  status_next;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [31:0] crc_out_q;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width      <= 8'd16;
			cfg_q.height     <= 8'd16;
			cfg_q.rate       <= 8'd30;
			cfg_q.ticks      <= 8'd60;
			cfg_q.frame_size <= 16'd128;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				lpv_pkg::REG_WIDTH:      cfg_q.width      <= pwdata[7:0];
				lpv_pkg::REG_HEIGHT:     cfg_q.height     <= pwdata[7:0];
				lpv_pkg::REG_RATE:       cfg_q.rate       <= pwdata[7:0];
				lpv_pkg::REG_TICKS:      cfg_q.ticks      <= pwdata[7:0];
				lpv_pkg::REG_FRAME_SIZE: cfg_q.frame_size <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			lpv_pkg::REG_WIDTH:      prdata = {24'd0, cfg_q.width};
			lpv_pkg::REG_HEIGHT:     prdata = {24'd0, cfg_q.height};
			lpv_pkg::REG_RATE:       prdata = {24'd0, cfg_q.rate};
			lpv_pkg::REG_TICKS:      prdata = {24'd0, cfg_q.ticks};
			lpv_pkg::REG_FRAME_SIZE: prdata = {16'd0, cfg_q.frame_size};
			default:                 prdata = 32'd0;
		endcase
	end

	// A word in the input stage moves on unless it would produce a result that has
	// nowhere to go.
	assign advance  = valid_s1 && (!fin_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			fin_s1  <= final_byte;
		end
	end

	// Stream processing of the word in the input stage.
	lpv_header_check u_check (
		.hdr     (hdr_q),
		.cfg     (cfg_q),
		.verdict (verdict)
	);

	lpv_crc8 u_crc (
		.crc_in  (crc_q),
		.data    (byte_s1),
		.crc_out (crc_upd)
	);

	assign in_header   = cnt_q < 32'(lpv_pkg::HEADER_BYTES);
	assign header_last = cnt_q == 32'(lpv_pkg::HEADER_BYTES - 1);
	assign cnt_next    = (cnt_q == lpv_pkg::ALL_ONES) ? cnt_q : cnt_q + 32'd1;
	assign crc_next    = in_header ? crc_q : crc_upd;

	// The last header byte is never checked, so the verdict can be taken from the
	// store in the same cycle that byte arrives.
	always_comb begin
		if (header_last) begin
			verdict_use = verdict;
		end else begin
			verdict_use.fault   = fault_q;
			verdict_use.size_ok = size_ok_q;
			verdict_use.total   = total_q;
		end
	end

	always_comb begin
		priority if (cnt_q < 32'(lpv_pkg::HEADER_BYTES - 1)) begin
			status_next = lpv_pkg::ST_TRUNC;
		end else if (verdict_use.fault != lpv_pkg::ST_OK) begin
			status_next = verdict_use.fault;
		end else if (!verdict_use.size_ok || ({1'b0, cnt_next} != verdict_use.total)) begin
			status_next = lpv_pkg::ST_SIZE;
		end else if ((crc_next ^ lpv_pkg::ALL_ONES) != hdr_q[191:160]) begin
			status_next = lpv_pkg::ST_CRC;
		end else begin
			status_next = lpv_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= 32'd0;
			crc_q     <= lpv_pkg::ALL_ONES;
			fault_q   <= lpv_pkg::ST_OK;
			size_ok_q <= 1'b0;
			total_q   <= 33'd0;
		end else if (advance) begin
			if (fin_s1) begin
				cnt_q   <= 32'd0;
				crc_q   <= lpv_pkg::ALL_ONES;
				fault_q <= lpv_pkg::ST_OK;
			end else begin
				cnt_q <= cnt_next;
				crc_q <= crc_next;
				if (header_last) begin
					fault_q   <= verdict.fault;
					size_ok_q <= verdict.size_ok;
					total_q   <= verdict.total;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_header) begin
			hdr_q[8*cnt_q[4:0] +: 8] <= byte_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && fin_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fin_s1) begin
			status_q  <= status_next;
			crc_out_q <= crc_next ^ lpv_pkg::ALL_ONES;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign payload_crc = crc_out_q;

endmodule
